// ===== sv/h3inv_pkg.sv =====
// Shared widths, constants and types of the homogeneous 3x3 inverse block.
package h3inv_pkg;

   localparam int COORD_W = 16;
   localparam int DIFF_W = COORD_W + 1;
   localparam int PROD_W = 2 * COORD_W + 1;
   localparam int TERM_W = COORD_W + DIFF_W;
   localparam int DET_W = TERM_W + 2;
   localparam int MAG_W = DET_W - 1;
   localparam int QUO_W = 48;
   localparam int NUM_LANES = 9;

   localparam int DEF_COORD_FRAC_BITS = 4;
   localparam int DEF_RESULT_FRAC_BITS = 24;

   localparam logic [QUO_W-1:0] POS_MAX = {1'b0, {(QUO_W - 1){1'b1}}};
   localparam logic [QUO_W-1:0] NEG_MIN = {1'b1, {(QUO_W - 1){1'b0}}};

   // One division lane: partial remainder, dividend bits still to shift in,
   // quotient bits so far, result sign and the early overflow mark.
   typedef struct packed {
      logic neg;
      logic ovf;
      logic [MAG_W-1:0] rem;
      logic [QUO_W-1:0] low;
      logic [QUO_W-1:0] quo;
   } div_lane_type;

   typedef div_lane_type [NUM_LANES-1:0] lane_vec_type;

   typedef struct packed {
      logic valid;
      logic singular;
   } pipe_ctl_type;

endpackage

// ===== sv/h3inv_front.sv =====
// Front stages: differences, cross products, determinant, magnitudes and divider setup.
module h3inv_front #(
   parameter int COORD_FRAC_BITS = h3inv_pkg::DEF_COORD_FRAC_BITS,
   parameter int RESULT_FRAC_BITS = h3inv_pkg::DEF_RESULT_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic signed [h3inv_pkg::COORD_W-1:0] x0,
   input  logic signed [h3inv_pkg::COORD_W-1:0] x1,
   input  logic signed [h3inv_pkg::COORD_W-1:0] x2,
   input  logic signed [h3inv_pkg::COORD_W-1:0] y0,
   input  logic signed [h3inv_pkg::COORD_W-1:0] y1,
   input  logic signed [h3inv_pkg::COORD_W-1:0] y2,
   output h3inv_pkg::pipe_ctl_type ctl,
   output logic [h3inv_pkg::MAG_W-1:0] den,
   output h3inv_pkg::lane_vec_type lanes
);
   import h3inv_pkg::*;

   localparam int SHIFT_DIFF = 2 * COORD_FRAC_BITS + RESULT_FRAC_BITS;
   localparam int SHIFT_PROD = COORD_FRAC_BITS + RESULT_FRAC_BITS;
   localparam int HI_W = MAG_W + SHIFT_DIFF;
   localparam int SH_W = HI_W + QUO_W;

   // Stage A: differences and coordinate products.
   logic a_valid_ff;
   logic signed [COORD_W-1:0] ax0_ff, ax1_ff, ax2_ff;
   logic signed [DIFF_W-1:0] dy12_ff, dx21_ff, dy20_ff, dx02_ff, dy01_ff, dx10_ff;
   logic signed [2*COORD_W-1:0] p12_ff, p21_ff, p20_ff, p02_ff, p01_ff, p10_ff;

   // Stage B: cross products and the three determinant terms.
   logic b_valid_ff;
   logic signed [DIFF_W-1:0] b_diff_ff [6];
   logic signed [PROD_W-1:0] c0_ff, c1_ff, c2_ff;
   logic signed [TERM_W-1:0] t0_ff, t1_ff, t2_ff;

   // Stage C: determinant and numerator magnitudes.
   logic c_valid_ff;
   logic signed [DET_W-1:0] det_ff;
   logic [MAG_W-1:0] c_nmag_ff [NUM_LANES];
   logic [NUM_LANES-1:0] c_nneg_ff;

   // Stage D: determinant magnitude and sign.
   logic d_valid_ff, d_sing_ff, d_dneg_ff;
   logic [MAG_W-1:0] d_dmag_ff;
   logic [MAG_W-1:0] d_nmag_ff [NUM_LANES];
   logic [NUM_LANES-1:0] d_nneg_ff;

   // Stage E: aligned dividend and overflow check.
   pipe_ctl_type e_ctl_ff;
   logic [MAG_W-1:0] e_den_ff;
   lane_vec_type e_lane_ff;

   logic signed [MAG_W-1:0] c_num_in [NUM_LANES];
   logic signed [DET_W-1:0] det_in;
   logic signed [DET_W-1:0] det_neg;
   lane_vec_type e_lane_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_ctl_ff <= '0;
      end else begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_ctl_ff <= '{valid: d_valid_ff, singular: d_sing_ff};
      end
   end

   always_ff @(posedge clock) begin
      ax0_ff <= x0;
      ax1_ff <= x1;
      ax2_ff <= x2;
      dy12_ff <= DIFF_W'(y1) - DIFF_W'(y2);
      dx21_ff <= DIFF_W'(x2) - DIFF_W'(x1);
      dy20_ff <= DIFF_W'(y2) - DIFF_W'(y0);
      dx02_ff <= DIFF_W'(x0) - DIFF_W'(x2);
      dy01_ff <= DIFF_W'(y0) - DIFF_W'(y1);
      dx10_ff <= DIFF_W'(x1) - DIFF_W'(x0);
      p12_ff <= x1 * y2;
      p21_ff <= x2 * y1;
      p20_ff <= x2 * y0;
      p02_ff <= x0 * y2;
      p01_ff <= x0 * y1;
      p10_ff <= x1 * y0;
   end

   always_ff @(posedge clock) begin
      b_diff_ff[0] <= dy12_ff;
      b_diff_ff[1] <= dx21_ff;
      b_diff_ff[2] <= dy20_ff;
      b_diff_ff[3] <= dx02_ff;
      b_diff_ff[4] <= dy01_ff;
      b_diff_ff[5] <= dx10_ff;
      c0_ff <= PROD_W'(p12_ff) - PROD_W'(p21_ff);
      c1_ff <= PROD_W'(p20_ff) - PROD_W'(p02_ff);
      c2_ff <= PROD_W'(p01_ff) - PROD_W'(p10_ff);
      t0_ff <= ax0_ff * dy12_ff;
      t1_ff <= ax1_ff * dy20_ff;
      t2_ff <= ax2_ff * dy01_ff;
   end

   // Numerators in row-major order of the inverse.
   always_comb begin
      c_num_in[0] = MAG_W'(b_diff_ff[0]);
      c_num_in[1] = MAG_W'(b_diff_ff[1]);
      c_num_in[2] = MAG_W'(c0_ff);
      c_num_in[3] = MAG_W'(b_diff_ff[2]);
      c_num_in[4] = MAG_W'(b_diff_ff[3]);
      c_num_in[5] = MAG_W'(c1_ff);
      c_num_in[6] = MAG_W'(b_diff_ff[4]);
      c_num_in[7] = MAG_W'(b_diff_ff[5]);
      c_num_in[8] = MAG_W'(c2_ff);
      det_in = DET_W'(t0_ff) + DET_W'(t1_ff) + DET_W'(t2_ff);
      det_neg = -det_ff;
   end

   always_ff @(posedge clock) begin
      det_ff <= det_in;
      for (int k = 0; k < NUM_LANES; k++) begin
         c_nneg_ff[k] <= c_num_in[k][MAG_W-1];
         c_nmag_ff[k] <= c_num_in[k][MAG_W-1] ? -c_num_in[k] : c_num_in[k];
      end
   end

   always_ff @(posedge clock) begin
      d_sing_ff <= (det_ff == '0);
      d_dneg_ff <= det_ff[DET_W-1];
      d_dmag_ff <= det_ff[DET_W-1] ? det_neg[MAG_W-1:0] : det_ff[MAG_W-1:0];
      d_nmag_ff <= c_nmag_ff;
      d_nneg_ff <= c_nneg_ff;
   end

   for (genvar k = 0; k < NUM_LANES; k++) begin : g_align
      localparam int SHIFT = ((k % 3) == 2) ? SHIFT_PROD : SHIFT_DIFF;
      logic [SH_W-1:0] wide;
      logic [HI_W-1:0] hi;
      always_comb begin
         wide = SH_W'(d_nmag_ff[k]) << SHIFT;
         hi = wide[SH_W-1:QUO_W];
         e_lane_in[k].neg = d_nneg_ff[k] ^ d_dneg_ff;
         // A quotient of 2^48 or more can only saturate.
         e_lane_in[k].ovf = (hi >= HI_W'(d_dmag_ff));
         e_lane_in[k].rem = hi[MAG_W-1:0];
         e_lane_in[k].low = wide[QUO_W-1:0];
         e_lane_in[k].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      e_den_ff <= d_dmag_ff;
      e_lane_ff <= e_lane_in;
   end

   assign ctl = e_ctl_ff;
   assign den = e_den_ff;
   assign lanes = e_lane_ff;

endmodule

// ===== sv/h3inv_divider.sv =====
// Pipelined restoring divider: nine lanes, one quotient bit per stage, shared divisor.
module h3inv_divider (
   input  logic clock,
   input  logic reset,
   input  h3inv_pkg::pipe_ctl_type in_ctl,
   input  logic [h3inv_pkg::MAG_W-1:0] in_den,
   input  h3inv_pkg::lane_vec_type in_lanes,
   output h3inv_pkg::pipe_ctl_type out_ctl,
   output h3inv_pkg::lane_vec_type out_lanes
);
   import h3inv_pkg::*;

   pipe_ctl_type ctl_ff [QUO_W];
   logic [MAG_W-1:0] den_ff [QUO_W];
   lane_vec_type lane_ff [QUO_W];

   function automatic div_lane_type div_step(div_lane_type cur, logic [MAG_W-1:0] d);
      logic [MAG_W:0] trial;
      logic [MAG_W:0] diff;
      div_lane_type nxt;
      trial = {cur.rem, cur.low[QUO_W-1]};
      diff = trial - {1'b0, d};
      nxt = cur;
      nxt.low = {cur.low[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
         nxt.rem = diff[MAG_W-1:0];
         nxt.quo = {cur.quo[QUO_W-2:0], 1'b1};
      end else begin
         nxt.rem = trial[MAG_W-1:0];
         nxt.quo = {cur.quo[QUO_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   for (genvar s = 0; s < QUO_W; s++) begin : g_stage
      pipe_ctl_type ctl_src;
      logic [MAG_W-1:0] den_src;
      lane_vec_type lane_src;
      lane_vec_type lane_in;

      if (s == 0) begin : g_first
         assign ctl_src = in_ctl;
         assign den_src = in_den;
         assign lane_src = in_lanes;
      end else begin : g_next
         assign ctl_src = ctl_ff[s-1];
         assign den_src = den_ff[s-1];
         assign lane_src = lane_ff[s-1];
      end

      always_comb begin
         for (int k = 0; k < NUM_LANES; k++) begin
            lane_in[k] = div_step(lane_src[k], den_src);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= '0;
         end else begin
            ctl_ff[s] <= ctl_src;
         end
      end

      always_ff @(posedge clock) begin
         den_ff[s] <= den_src;
         lane_ff[s] <= lane_in;
      end
   end

   assign out_ctl = ctl_ff[QUO_W-1];
   assign out_lanes = lane_ff[QUO_W-1];

endmodule

// ===== sv/h3inv_output.sv =====
// Output stage: sign, saturation, singular override and the result register.
module h3inv_output (
   input  logic clock,
   input  logic reset,
   input  h3inv_pkg::pipe_ctl_type in_ctl,
   input  h3inv_pkg::lane_vec_type in_lanes,
   output logic out_valid,
   output logic out_singular,
   output logic [h3inv_pkg::NUM_LANES-1:0][h3inv_pkg::QUO_W-1:0] out_vals
);
   import h3inv_pkg::*;

   logic valid_ff;
   logic singular_ff;
   logic [NUM_LANES-1:0][QUO_W-1:0] vals_ff;
   logic [NUM_LANES-1:0][QUO_W-1:0] vals_in;

   always_comb begin
      for (int k = 0; k < NUM_LANES; k++) begin
         if (in_ctl.singular) begin
            vals_in[k] = '0;
         end else if (in_lanes[k].ovf || in_lanes[k].quo[QUO_W-1]) begin
            vals_in[k] = in_lanes[k].neg ? NEG_MIN : POS_MAX;
         end else if (in_lanes[k].neg) begin
            vals_in[k] = -in_lanes[k].quo;
         end else begin
            vals_in[k] = in_lanes[k].quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      singular_ff <= in_ctl.singular;
      vals_ff <= vals_in;
   end

   assign out_valid = valid_ff;
   assign out_singular = singular_ff;
   assign out_vals = vals_ff;

endmodule

// ===== sv/homogeneous_3x3_inverse_top.sv =====
// Top level of the homogeneous 3x3 inverse block.
//
//   channel   ports                          transfer when
//   request   req_x0..req_y2                 start high and busy low
//   response  rsp_inv_r0c0..r2c2, singular   rsp_valid high (one cycle)
//
// A new triangle may start in every cycle; busy stays low.
// The pipeline has five front stages, one stage per quotient bit of the
// 48-bit divider, and one output register.
// Synchronous reset clears the valid bits of every stage.
// Responses cannot be held off; each is shown for one cycle only.
module homogeneous_3x3_inverse_top #(
   parameter int COORD_FRAC_BITS = h3inv_pkg::DEF_COORD_FRAC_BITS,
   parameter int RESULT_FRAC_BITS = h3inv_pkg::DEF_RESULT_FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic signed [h3inv_pkg::COORD_W-1:0] req_x0,
   input  logic signed [h3inv_pkg::COORD_W-1:0] req_x1,
   input  logic signed [h3inv_pkg::COORD_W-1:0] req_x2,
   input  logic signed [h3inv_pkg::COORD_W-1:0] req_y0,
   input  logic signed [h3inv_pkg::COORD_W-1:0] req_y1,
   input  logic signed [h3inv_pkg::COORD_W-1:0] req_y2,
   output logic rsp_valid,
   output logic signed [h3inv_pkg::QUO_W-1:0] rsp_inv_r0c0,
   output logic signed [h3inv_pkg::QUO_W-1:0] rsp_inv_r0c1,
   output logic signed [h3inv_pkg::QUO_W-1:0] rsp_inv_r0c2,
   output logic signed [h3inv_pkg::QUO_W-1:0] rsp_inv_r1c0,
   output logic signed [h3inv_pkg::QUO_W-1:0] rsp_inv_r1c1,
   output logic signed [h3inv_pkg::QUO_W-1:0] rsp_inv_r1c2,
   output logic signed [h3inv_pkg::QUO_W-1:0] rsp_inv_r2c0,
   output logic signed [h3inv_pkg::QUO_W-1:0] rsp_inv_r2c1,
   output logic signed [h3inv_pkg::QUO_W-1:0] rsp_inv_r2c2,
   output logic rsp_singular
);
   import h3inv_pkg::*;

   pipe_ctl_type front_ctl;
   logic [MAG_W-1:0] front_den;
   lane_vec_type front_lanes;
   pipe_ctl_type div_ctl;
   lane_vec_type div_lanes;
   logic [NUM_LANES-1:0][QUO_W-1:0] vals;

   assign busy = 1'b0;

   h3inv_front #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS),
      .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(start & ~busy),
      .x0(req_x0),
      .x1(req_x1),
      .x2(req_x2),
      .y0(req_y0),
      .y1(req_y1),
      .y2(req_y2),
      .ctl(front_ctl),
      .den(front_den),
      .lanes(front_lanes)
   );

   h3inv_divider u_divider (
      .clock(clock),
      .reset(reset),
      .in_ctl(front_ctl),
      .in_den(front_den),
      .in_lanes(front_lanes),
      .out_ctl(div_ctl),
      .out_lanes(div_lanes)
   );

   h3inv_output u_output (
      .clock(clock),
      .reset(reset),
      .in_ctl(div_ctl),
      .in_lanes(div_lanes),
      .out_valid(rsp_valid),
      .out_singular(rsp_singular),
      .out_vals(vals)
   );

   assign rsp_inv_r0c0 = vals[0];
   assign rsp_inv_r0c1 = vals[1];
   assign rsp_inv_r0c2 = vals[2];
   assign rsp_inv_r1c0 = vals[3];
   assign rsp_inv_r1c1 = vals[4];
   assign rsp_inv_r1c2 = vals[5];
   assign rsp_inv_r2c0 = vals[6];
   assign rsp_inv_r2c1 = vals[7];
   assign rsp_inv_r2c2 = vals[8];

endmodule

// ===== tb/homogeneous_3x3_inverse_checker.sv =====
// Checker that predicts and compares the responses of the 3x3 inverse block.
`timescale 1ns / 1ps
module homogeneous_3x3_inverse_checker (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic busy,
   input  logic signed [h3inv_pkg::COORD_W-1:0] req_x0,
   input  logic signed [h3inv_pkg::COORD_W-1:0] req_x1,
   input  logic signed [h3inv_pkg::COORD_W-1:0] req_x2,
   input  logic signed [h3inv_pkg::COORD_W-1:0] req_y0,
   input  logic signed [h3inv_pkg::COORD_W-1:0] req_y1,
   input  logic signed [h3inv_pkg::COORD_W-1:0] req_y2,
   input  logic rsp_valid,
   input  logic [h3inv_pkg::NUM_LANES*h3inv_pkg::QUO_W-1:0] rsp_entries,
   input  logic rsp_singular,
   output int fail_count,
   output int pending_count
);
   import h3inv_pkg::*;

   localparam int CF = DEF_COORD_FRAC_BITS;
   localparam int RF = DEF_RESULT_FRAC_BITS;

   typedef struct {
      logic [QUO_W-1:0] entry [NUM_LANES];
      logic singular;
   } inverse_type;

   inverse_type expected_inverses [$];

   // Exact quotient num * 2^shift / den, truncated toward zero, then saturated.
   function automatic logic [QUO_W-1:0] scaled_quotient(longint num, longint den, int shift);
      logic [127:0] n, d, q;
      logic neg;
      neg = (num < 0) != (den < 0);
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      q = (n << shift) / d;
      if (!neg) return q > {80'd0, POS_MAX} ? POS_MAX : q[QUO_W-1:0];
      if (q > {80'd0, NEG_MIN}) return NEG_MIN;
      return -q[QUO_W-1:0];
   endfunction

   function automatic inverse_type predict_inverse(longint x0, longint x1, longint x2,
                                                   longint y0, longint y1, longint y2);
      inverse_type r;
      longint adj [NUM_LANES];
      longint det;
      adj[0] = y1 - y2;  adj[1] = x2 - x1;  adj[2] = x1 * y2 - x2 * y1;
      adj[3] = y2 - y0;  adj[4] = x0 - x2;  adj[5] = x2 * y0 - x0 * y2;
      adj[6] = y0 - y1;  adj[7] = x1 - x0;  adj[8] = x0 * y1 - x1 * y0;
      det = x0 * adj[0] + x1 * adj[3] + x2 * adj[6];
      r.singular = (det == 0);
      for (int k = 0; k < NUM_LANES; k++)
         r.entry[k] = r.singular ? '0
                    : scaled_quotient(adj[k], det, (k % 3 == 2) ? CF + RF : 2 * CF + RF);
      return r;
   endfunction

   always @(posedge clock) begin
      inverse_type want;
      int errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (rsp_valid) begin
            if (expected_inverses.size() == 0) begin
               $error("response with no transfer outstanding");
               errs++;
            end else begin
               want = expected_inverses.pop_front();
               for (int k = 0; k < NUM_LANES; k++)
                  if (rsp_entries[k*QUO_W +: QUO_W] !== want.entry[k]) begin
                     $error("inv_r%0dc%0d expected %h actual %h", k / 3, k % 3,
                            want.entry[k], rsp_entries[k*QUO_W +: QUO_W]);
                     errs++;
                  end
               if (rsp_singular !== want.singular) begin
                  $error("singular expected %b actual %b", want.singular, rsp_singular);
                  errs++;
               end
            end
         end
         if (start && !busy)
            expected_inverses.push_back(predict_inverse(req_x0, req_x1, req_x2,
                                                        req_y0, req_y1, req_y2));
         fail_count <= fail_count + errs;
      end
      pending_count <= expected_inverses.size();
   end

endmodule

// ===== tb/homogeneous_3x3_inverse_top_tb.sv =====
// Stimulus and verdict for the homogeneous 3x3 inverse block.
`timescale 1ns / 1ps
module homogeneous_3x3_inverse_top_tb;
   import h3inv_pkg::*;

   localparam int LATENCY = 54;
   localparam int IDLE_LIMIT = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [COORD_W-1:0] req_x0 = '0, req_x1 = '0, req_x2 = '0;
   logic signed [COORD_W-1:0] req_y0 = '0, req_y1 = '0, req_y2 = '0;
   logic rsp_valid, rsp_singular;
   logic signed [QUO_W-1:0] rsp_inv [NUM_LANES];
   logic [NUM_LANES*QUO_W-1:0] rsp_entries;
   int fail_count, pending_count;
   int idle_cycles = 0;

   homogeneous_3x3_inverse_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x0(req_x0), .req_x1(req_x1), .req_x2(req_x2),
      .req_y0(req_y0), .req_y1(req_y1), .req_y2(req_y2),
      .rsp_valid(rsp_valid),
      .rsp_inv_r0c0(rsp_inv[0]), .rsp_inv_r0c1(rsp_inv[1]), .rsp_inv_r0c2(rsp_inv[2]),
      .rsp_inv_r1c0(rsp_inv[3]), .rsp_inv_r1c1(rsp_inv[4]), .rsp_inv_r1c2(rsp_inv[5]),
      .rsp_inv_r2c0(rsp_inv[6]), .rsp_inv_r2c1(rsp_inv[7]), .rsp_inv_r2c2(rsp_inv[8]),
      .rsp_singular(rsp_singular)
   );

   always_comb
      for (int k = 0; k < NUM_LANES; k++) rsp_entries[k*QUO_W +: QUO_W] = rsp_inv[k];

   homogeneous_3x3_inverse_checker checker_i (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_x0(req_x0), .req_x1(req_x1), .req_x2(req_x2),
      .req_y0(req_y0), .req_y1(req_y1), .req_y2(req_y2),
      .rsp_valid(rsp_valid), .rsp_entries(rsp_entries), .rsp_singular(rsp_singular),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: counts cycles in which neither a request nor a response moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("homogeneous_3x3_inverse_top_tb: errors");
         $finish;
      end
   end

   logic signed [COORD_W-1:0] tri_x0, tri_x1, tri_x2, tri_y0, tri_y1, tri_y2;

   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'(signed'($urandom_range(0, 16)) - 8);
         3, 4: return 16'(signed'($urandom_range(0, 512)) - 256);
         default: return 16'($urandom());
      endcase
   endfunction

   // Holds one triangle on the ports until it is accepted.
   task automatic send_triangle();
      @(negedge clock);
      start <= 1'b1;
      req_x0 <= tri_x0; req_x1 <= tri_x1; req_x2 <= tri_x2;
      req_y0 <= tri_y0; req_y1 <= tri_y1; req_y2 <= tri_y2;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic set_triangle(int a, int b, int c, int d, int e, int f);
      tri_x0 = COORD_W'(a); tri_x1 = COORD_W'(b); tri_x2 = COORD_W'(c);
      tri_y0 = COORD_W'(d); tri_y1 = COORD_W'(e); tri_y2 = COORD_W'(f);
   endtask

   task automatic pause(int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   initial begin
      int burst, drain;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: identity-like, extremes and singular cases.
      set_triangle(0, 16, 0, 0, 0, 16);                 send_triangle();
      set_triangle(0, 0, 0, 0, 0, 0);                   send_triangle();
      set_triangle(5, 5, 5, 1, 2, 3);                   send_triangle();
      set_triangle(1, 2, 3, 2, 4, 6);                   send_triangle();
      set_triangle(0, 1, 0, 0, 0, 1);                   send_triangle();
      set_triangle(-32768, 32767, 0, -32768, -32768, 32767); send_triangle();
      set_triangle(32767, -32768, 32767, 32767, 0, -32768);  send_triangle();
      set_triangle(-32768, -32768, 32767, 32767, -32768, -32768); send_triangle();
      set_triangle(-1, 0, 0, 0, -1, 0);                 send_triangle();
      set_triangle(0, 32767, -32768, 0, 1, 0);          send_triangle();
      set_triangle(1, 0, 0, 0, 1, 1);                   send_triangle();
      set_triangle(-16, 16, 0, 0, 0, -16);              send_triangle();
      set_triangle(-1, -1, -1, -1, -1, -1);             send_triangle();
      set_triangle(3, -7, 11, -13, 17, -19);            send_triangle();
      pause(3);

      for (int n = 0; n < 1550; ) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst; b++, n++) begin
            tri_x0 = pick_coord(); tri_x1 = pick_coord(); tri_x2 = pick_coord();
            tri_y0 = pick_coord(); tri_y1 = pick_coord(); tri_y2 = pick_coord();
            // Some triangles are made degenerate on purpose.
            if ($urandom_range(0, 15) == 0) begin
               tri_x2 = tri_x1; tri_y2 = tri_y1;
            end
            send_triangle();
         end
         if ($urandom_range(0, 3) != 0) pause($urandom_range(0, 60));
      end
      pause(0);

      drain = 0;
      while (pending_count != 0 && drain < 20 * LATENCY) begin
         @(posedge clock);
         drain++;
      end
      repeat (LATENCY) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("homogeneous_3x3_inverse_top_tb: clean");
      else
         $display("homogeneous_3x3_inverse_top_tb: errors");
      $finish;
   end
endmodule
